/* rtl/core/dbp_pkg.sv */
`timescale 1ns / 1ps

package dbp_pkg;

    // fixed point format of coordinates, distances and settings
    localparam int FRAC_BITS = 16;

    localparam int EPS_RAW = ((1 << FRAC_BITS) + 500) / 1000;
    localparam int EPS     = (EPS_RAW < 1) ? 1 : EPS_RAW;
    localparam int WLO     = ((8 << FRAC_BITS) + 50) / 100;
    localparam int WHI     = ((82 << FRAC_BITS) + 50) / 100;

    // unit value of the near factor and of the eased parameter, Q0.16
    localparam int ONE_Q16 = 65536;

    localparam int COORD_W = 32;
    localparam int RAD_W   = 64;
    localparam int ROOT_W  = 32;
    // rounded quotient can reach exactly one, so it needs 17 bits
    localparam int NUM_W   = 48;
    localparam int QUOT_W  = 17;
    localparam int NEAR_W  = 17;
    localparam int WID_W   = 16;

    typedef enum logic [2:0] {
        REG_NEAR_DIST  = 3'd0,
        REG_FAR_DIST   = 3'd1,
        REG_NEAR_LIFT  = 3'd2,
        REG_FAR_LIFT   = 3'd3,
        REG_NEAR_WIDTH = 3'd4,
        REG_FAR_WIDTH  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] anchor_x;
        logic signed [COORD_W-1:0] anchor_y;
        logic signed [COORD_W-1:0] anchor_z;
        logic signed [COORD_W-1:0] cam_x;
        logic signed [COORD_W-1:0] cam_z;
    } req_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] placed_x;
        logic signed [COORD_W-1:0] placed_y;
        logic signed [COORD_W-1:0] placed_z;
        logic        [NEAR_W-1:0]  nearness;
        logic        [WID_W-1:0]   width_ratio;
    } res_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] near_dist;
        logic signed [COORD_W-1:0] far_dist;
        logic signed [COORD_W-1:0] near_lift;
        logic signed [COORD_W-1:0] far_lift;
        logic signed [COORD_W-1:0] near_width;
        logic signed [COORD_W-1:0] far_width;
    } cfg_t;

    // anchor coordinates that ride along the pipeline
    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] az;
    } anchor_t;

    // outcome of the range check ahead of the divider
    typedef struct packed {
        anchor_t anc;
        logic    at_zero;
        logic    at_one;
    } div_side_t;

endpackage

/* rtl/core/dbp_regs.sv */
`timescale 1ns / 1ps

module dbp_regs
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output dbp_pkg::cfg_t cfg
);
    import dbp_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr;

    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.near_dist  <= 32'sd0;
            cfg_reg.far_dist   <= 32'sd655360;
            cfg_reg.near_lift  <= 32'sd0;
            cfg_reg.far_lift   <= 32'sd0;
            cfg_reg.near_width <= 32'sd19661;
            cfg_reg.far_width  <= 32'sd19661;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_NEAR_DIST:  cfg_reg.near_dist  <= pwdata;
                REG_FAR_DIST:   cfg_reg.far_dist   <= pwdata;
                REG_NEAR_LIFT:  cfg_reg.near_lift  <= pwdata;
                REG_FAR_LIFT:   cfg_reg.far_lift   <= pwdata;
                REG_NEAR_WIDTH: cfg_reg.near_width <= pwdata;
                REG_FAR_WIDTH:  cfg_reg.far_width  <= pwdata;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_NEAR_DIST:  prdata = cfg_reg.near_dist;
            REG_FAR_DIST:   prdata = cfg_reg.far_dist;
            REG_NEAR_LIFT:  prdata = cfg_reg.near_lift;
            REG_FAR_LIFT:   prdata = cfg_reg.far_lift;
            REG_NEAR_WIDTH: prdata = cfg_reg.near_width;
            REG_FAR_WIDTH:  prdata = cfg_reg.far_width;
            default:        prdata = '0;
        endcase
    end

endmodule

/* rtl/core/dbp_sqrt.sv */
`timescale 1ns / 1ps

// one root bit per stage, remainder method
module dbp_sqrt
#(
    parameter int SIDE_W = 96
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [dbp_pkg::RAD_W-1:0]  in_rad,
    input  logic [SIDE_W-1:0]          in_side,
    output logic                       out_valid,
    output logic [dbp_pkg::ROOT_W-1:0] out_root,
    output logic [SIDE_W-1:0]          out_side
);
    import dbp_pkg::*;

    localparam int N = ROOT_W;

    logic                valid_reg [N];
    logic [RAD_W-1:0]    rad_reg   [N];
    logic [ROOT_W+1:0]   rem_reg   [N];
    logic [ROOT_W-1:0]   root_reg  [N];
    logic [SIDE_W-1:0]   side_reg  [N];

    for (genvar j = 0; j < N; j++)
    begin : g_stage
        logic              v_in;
        logic [RAD_W-1:0]  rad_in;
        logic [ROOT_W+1:0] rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SIDE_W-1:0] side_in;
        logic [ROOT_W+3:0] acc;
        logic [ROOT_W+3:0] trial;
        logic              take;

        if (j == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rad_in  = in_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign v_in    = valid_reg[j-1];
            assign rad_in  = rad_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
            assign side_in = side_reg[j-1];
        end

        assign acc   = {rem_in, rad_in[RAD_W-1 -: 2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign take  = (acc >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[j] <= 1'b0;
            else if (en)
                valid_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[j]  <= {rad_in[RAD_W-3:0], 2'b00};
                side_reg[j] <= side_in;
                if (take)
                begin
                    rem_reg[j]  <= (ROOT_W+2)'(acc - trial);
                    root_reg[j] <= {root_in[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[j]  <= (ROOT_W+2)'(acc);
                    root_reg[j] <= {root_in[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_root  = root_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

/* rtl/core/dbp_div.sv */
`timescale 1ns / 1ps

// restoring divider, one quotient bit per stage; dividend top part below divisor
module dbp_div
#(
    parameter int SIDE_W = 98
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [dbp_pkg::NUM_W-1:0]  in_num,
    input  logic [31:0]                divisor,
    input  logic [SIDE_W-1:0]          in_side,
    output logic                       out_valid,
    output logic [dbp_pkg::QUOT_W-1:0] out_quot,
    output logic [SIDE_W-1:0]          out_side
);
    import dbp_pkg::*;

    localparam int N     = QUOT_W;
    localparam int REM_W = NUM_W - QUOT_W;

    logic              valid_reg [N];
    logic [REM_W-1:0]  rem_reg   [N];
    logic [QUOT_W-1:0] low_reg   [N];
    logic [QUOT_W-1:0] quot_reg  [N];
    logic [SIDE_W-1:0] side_reg  [N];

    for (genvar j = 0; j < N; j++)
    begin : g_stage
        logic              v_in;
        logic [REM_W-1:0]  rem_in;
        logic [QUOT_W-1:0] low_in;
        logic [QUOT_W-1:0] quot_in;
        logic [SIDE_W-1:0] side_in;
        logic [REM_W:0]    acc;
        logic              take;

        if (j == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = in_num[NUM_W-1:QUOT_W];
            assign low_in  = in_num[QUOT_W-1:0];
            assign quot_in = '0;
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign v_in    = valid_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign low_in  = low_reg[j-1];
            assign quot_in = quot_reg[j-1];
            assign side_in = side_reg[j-1];
        end

        assign acc  = {rem_in, low_in[QUOT_W-1]};
        assign take = (acc >= divisor);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[j] <= 1'b0;
            else if (en)
                valid_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                low_reg[j]  <= {low_in[QUOT_W-2:0], 1'b0};
                side_reg[j] <= side_in;
                quot_reg[j] <= {quot_in[QUOT_W-2:0], take};
                if (take)
                    rem_reg[j] <= REM_W'(acc - divisor);
                else
                    rem_reg[j] <= REM_W'(acc);
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_quot  = quot_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

/* rtl/core/distance_eased_billboard_place_core.sv */
`timescale 1ns / 1ps

// distance eased billboard placement
//
// request channel (req_valid/req_ready/req_data): anchor x/y/z and camera x/z,
// signed Q16.16. result channel (res_valid/res_ready/res_data): placed anchor,
// near factor (Q0.16) and clamped width ratio. settings sit behind a small
// apb-style port, one 32-bit register per word, pready tied high
//
// throughput: one request per cycle while the result register is not held
// back; the depth comes from the 32-stage square root (one root bit per
// stage) and the 17-stage divider (one quotient bit per stage)
//
// the whole pipeline moves as one: when the result register holds an item
// the receiver has not taken, every stage holds and req_ready drops, so no
// request is lost or repeated. reset clears all valid bits and loads the
// default settings; nothing else needs clearing
module distance_eased_billboard_place_core
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  dbp_pkg::req_t   req_data,
    output logic            res_valid,
    input  logic            res_ready,
    output dbp_pkg::res_t   res_data,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [4:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    import dbp_pkg::*;

    cfg_t cfg;
    logic en;

    dbp_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // global advance: the output register is free or being emptied
    logic out_valid_reg;
    assign en        = ~out_valid_reg | res_ready;
    assign req_ready = en;

    // derived distance bounds, settled long before any request reaches them
    logic [31:0]        snear_next;
    logic signed [33:0] sfar_min;
    logic signed [33:0] sfar;
    logic [31:0]        snear_reg;
    logic [31:0]        span_reg;

    always_comb
    begin
        snear_next = cfg.near_dist[31] ? 32'd0 : cfg.near_dist;
        sfar_min   = $signed({2'b00, snear_next}) + 34'sd1 * EPS;
        sfar       = ($signed(34'(cfg.far_dist)) > sfar_min) ? 34'(cfg.far_dist) : sfar_min;
    end

    always_ff @(posedge clk)
    begin
        snear_reg <= snear_next;
        span_reg  <= 32'(sfar - $signed({2'b00, snear_next}));
    end

    // stage 0: absolute x/z offsets
    logic               s0_valid_reg;
    anchor_t            s0_anc_reg;
    logic [31:0]        s0_mx_reg;
    logic [31:0]        s0_mz_reg;
    logic signed [32:0] dx;
    logic signed [32:0] dz;

    assign dx = 33'(req_data.cam_x) - 33'(req_data.anchor_x);
    assign dz = 33'(req_data.cam_z) - 33'(req_data.anchor_z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (en)
            s0_valid_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_anc_reg <= '{req_data.anchor_x, req_data.anchor_y, req_data.anchor_z};
            s0_mx_reg  <= dx[32] ? 32'(-dx) : 32'(dx);
            s0_mz_reg  <= dz[32] ? 32'(-dz) : 32'(dz);
        end
    end

    // stage 1: squares
    logic        s1_valid_reg;
    anchor_t     s1_anc_reg;
    logic [63:0] s1_sq1_reg;
    logic [63:0] s1_sq2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= s0_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_anc_reg <= s0_anc_reg;
            s1_sq1_reg <= 64'(s0_mx_reg) * 64'(s0_mx_reg);
            s1_sq2_reg <= 64'(s0_mz_reg) * 64'(s0_mz_reg);
        end
    end

    // stage 2: sum of squares, saturated to 64 bits
    logic        s2_valid_reg;
    anchor_t     s2_anc_reg;
    logic [63:0] s2_sum_reg;
    logic [64:0] sum_wide;

    assign sum_wide = 65'(s1_sq1_reg) + 65'(s1_sq2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_anc_reg <= s1_anc_reg;
            s2_sum_reg <= sum_wide[64] ? '1 : sum_wide[63:0];
        end
    end

    // horizontal distance
    logic        sq_valid;
    logic [31:0] sq_root;
    anchor_t     sq_anc;

    dbp_sqrt #(.SIDE_W($bits(anchor_t))) u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_valid_reg),
        .in_rad    (s2_sum_reg),
        .in_side   (s2_anc_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_anc)
    );

    // stage 3: range check and dividend for the linear parameter
    logic             s3_valid_reg;
    div_side_t        s3_side_reg;
    logic [NUM_W-1:0] s3_num_reg;
    logic             below;
    logic [32:0]      offs;
    logic             beyond;

    assign below  = ({1'b0, sq_root} <= {1'b0, snear_reg});
    assign offs   = {1'b0, sq_root} - {1'b0, snear_reg};
    assign beyond = (offs >= {1'b0, span_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (en)
            s3_valid_reg <= sq_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_side_reg.anc     <= sq_anc;
            s3_side_reg.at_zero <= below;
            s3_side_reg.at_one  <= ~below & beyond;
            if (below | beyond)
                s3_num_reg <= '0;
            else
                s3_num_reg <= NUM_W'({offs[30:0], 16'h0000}) + NUM_W'(span_reg[31:1]);
        end
    end

    // rounded quotient, Q0.16, may reach exactly one
    logic              dv_valid;
    logic [QUOT_W-1:0] dv_quot;
    div_side_t         dv_side;

    dbp_div #(.SIDE_W($bits(div_side_t))) u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .in_num    (s3_num_reg),
        .divisor   (span_reg),
        .in_side   (s3_side_reg),
        .out_valid (dv_valid),
        .out_quot  (dv_quot),
        .out_side  (dv_side)
    );

    // stage 4: t and t squared
    logic        s4_valid_reg;
    anchor_t     s4_anc_reg;
    logic [16:0] s4_t_reg;
    logic [32:0] s4_tt_reg;
    logic [16:0] t_val;

    always_comb
    begin
        priority if (dv_side.at_zero)
            t_val = '0;
        else if (dv_side.at_one)
            t_val = 17'(ONE_Q16);
        else
            t_val = dv_quot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (en)
            s4_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_anc_reg <= dv_side.anc;
            s4_t_reg   <= t_val;
            s4_tt_reg  <= 33'(34'(t_val) * 34'(t_val));
        end
    end

    // stage 5: t*t*(3 - 2t)
    logic        s5_valid_reg;
    anchor_t     s5_anc_reg;
    logic [50:0] s5_prod_reg;
    logic [17:0] fac;

    assign fac = 18'(3 * ONE_Q16) - {s4_t_reg, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else if (en)
            s5_valid_reg <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_anc_reg  <= s4_anc_reg;
            s5_prod_reg <= 51'(s4_tt_reg) * 51'(fac);
        end
    end

    // stage 6: rounded smoothstep and near factor
    logic        s6_valid_reg;
    anchor_t     s6_anc_reg;
    logic [16:0] s6_n_reg;
    logic [50:0] prod_rnd;

    assign prod_rnd = s5_prod_reg + 51'h0_0000_8000_0000;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_valid_reg <= 1'b0;
        else if (en)
            s6_valid_reg <= s5_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_anc_reg <= s5_anc_reg;
            s6_n_reg   <= 17'(ONE_Q16) - prod_rnd[48:32];
        end
    end

    // stage 7: blend products
    logic               s7_valid_reg;
    anchor_t            s7_anc_reg;
    logic [16:0]        s7_n_reg;
    logic signed [49:0] s7_lf_reg;
    logic signed [49:0] s7_ln_reg;
    logic signed [49:0] s7_wf_reg;
    logic signed [49:0] s7_wn_reg;
    logic signed [17:0] w_far;
    logic signed [17:0] w_near;

    assign w_near = $signed({1'b0, s6_n_reg});
    assign w_far  = $signed({1'b0, 17'(ONE_Q16) - s6_n_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s7_valid_reg <= 1'b0;
        else if (en)
            s7_valid_reg <= s6_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_anc_reg <= s6_anc_reg;
            s7_n_reg   <= s6_n_reg;
            s7_lf_reg  <= cfg.far_lift * w_far;
            s7_ln_reg  <= cfg.near_lift * w_near;
            s7_wf_reg  <= cfg.far_width * w_far;
            s7_wn_reg  <= cfg.near_width * w_near;
        end
    end

    // stage 8: blended lift and width, rounded half up with a floor shift
    logic               s8_valid_reg;
    anchor_t            s8_anc_reg;
    logic [16:0]        s8_n_reg;
    logic signed [31:0] s8_lift_reg;
    logic signed [31:0] s8_width_reg;
    logic signed [50:0] lift_tot;
    logic signed [50:0] width_tot;

    assign lift_tot  = 51'(s7_lf_reg) + 51'(s7_ln_reg) + 51'sd32768;
    assign width_tot = 51'(s7_wf_reg) + 51'(s7_wn_reg) + 51'sd32768;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s8_valid_reg <= 1'b0;
        else if (en)
            s8_valid_reg <= s7_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s8_anc_reg   <= s7_anc_reg;
            s8_n_reg     <= s7_n_reg;
            s8_lift_reg  <= lift_tot[47:16];
            s8_width_reg <= width_tot[47:16];
        end
    end

    // output register: saturated y and clamped width
    res_t               out_data_reg;
    logic signed [32:0] y_sum;
    logic signed [31:0] y_sat;
    logic signed [31:0] w_clamp;

    assign y_sum = 33'(s8_anc_reg.ay) + 33'(s8_lift_reg);

    always_comb
    begin
        priority if (y_sum > 33'sh0_7FFF_FFFF)
            y_sat = 32'sh7FFF_FFFF;
        else if (y_sum < -33'sh0_8000_0000)
            y_sat = 32'sh8000_0000;
        else
            y_sat = y_sum[31:0];

        priority if (s8_width_reg < $signed(32'(WLO)))
            w_clamp = 32'(WLO);
        else if (s8_width_reg > $signed(32'(WHI)))
            w_clamp = 32'(WHI);
        else
            w_clamp = s8_width_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= s8_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg.placed_x    <= s8_anc_reg.ax;
            out_data_reg.placed_y    <= y_sat;
            out_data_reg.placed_z    <= s8_anc_reg.az;
            out_data_reg.nearness    <= s8_n_reg;
            out_data_reg.width_ratio <= w_clamp[15:0];
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

endmodule

/* rtl/core/dbp_check.sv */
`timescale 1ns / 1ps

module dbp_check
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_ready,
    input  logic          res_valid,
    input  logic          res_ready,
    input  dbp_pkg::res_t res_data,
    input  logic          pready
);
    import dbp_pkg::*;

    // a result not taken stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // a stalled output blocks new requests
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |-> !req_ready)
        else $error("request taken while output stalled");

    a_near_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.nearness <= 17'(ONE_Q16))
        else $error("near factor out of range");

    a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_data.width_ratio >= 16'(WLO)) && (res_data.width_ratio <= 16'(WHI)))
        else $error("width ratio outside clamp");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("config port not ready");

endmodule

bind distance_eased_billboard_place_core dbp_check u_dbp_check
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .pready    (pready)
);
